>>> design/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg: shared types and constants of the rpn stack evaluator
// request codes, status codes, default sizes and the alu request bundle
// ----------------------------------------------------------------------------
package rse_pkg;

	// default sizes of the stack and of one stored value
	localparam int STACK_DEPTH_DEF = 16;
	localparam int DATA_WIDTH_DEF  = 32;

	// fixed field widths of the stream beats
	localparam int OPV_W  = 32;
	localparam int TOP_W  = 32;
	localparam int CNT_W  = 5;
	localparam int STAT_W = 3;
	localparam int REQ_W  = 3;

	// token kinds
	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH   = 3'd0,
		REQ_ADD    = 3'd1,
		REQ_SUB    = 3'd2,
		REQ_MUL    = 3'd3,
		REQ_DIV    = 3'd4,
		REQ_STORE  = 3'd5,
		REQ_RECALL = 3'd6,
		REQ_FINISH = 3'd7
	} req_type_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 3'd0,
		ST_UNDER   = 3'd1,
		ST_OVER    = 3'd2,
		ST_DIVZ    = 3'd3,
		ST_INVALID = 3'd4
	} status_t;

	// request from the sequencer to the shared alu
	typedef struct packed {
		logic      start;
		req_type_t op;
	} alu_req_t;

endpackage

>>> design/rse_stack_ram.sv
// ----------------------------------------------------------------------------
// rse_stack_ram: operand stack storage
// one write port, two registered read ports
// ----------------------------------------------------------------------------
module rse_stack_ram #(
	parameter int DEPTH = rse_pkg::STACK_DEPTH_DEF,
	parameter int W     = rse_pkg::DATA_WIDTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [W-1:0]  wr_data,
	input  logic [AW-1:0] rd_addr_a,
	input  logic [AW-1:0] rd_addr_b,
	output logic [W-1:0]  rd_data_a,
	output logic [W-1:0]  rd_data_b
);

	logic [W-1:0] mem [DEPTH];

	// write and registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

>>> design/rse_alu.sv
// ----------------------------------------------------------------------------
// rse_alu: shared iterative arithmetic unit
// one adder/subtractor serves add, subtract, shift-add multiply and
// restoring divide with sign fix-up; result comes with a one-cycle done
// ----------------------------------------------------------------------------
module rse_alu #(
	parameter int W = rse_pkg::DATA_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rse_pkg::alu_req_t req,
	input  logic [W-1:0]      a,
	input  logic [W-1:0]      b,
	output logic              done,
	output logic [W-1:0]      result
);

	localparam int CW = $clog2(W);

	typedef enum logic [2:0] {
		A_IDLE,
		A_ADDSUB,
		A_MUL,
		A_NEGA,
		A_NEGB,
		A_DIV,
		A_NEGQ
	} alu_state_t;

	alu_state_t         state_q;
	rse_pkg::req_type_t op_q;
	logic [W-1:0]       a_q;
	logic [W-1:0]       b_q;
	logic [W-1:0]       acc_q;
	logic [CW-1:0]      cnt_q;
	logic               sign_q;
	logic               done_q;
	logic [W-1:0]       result_q;

	logic [W:0]   add_a;
	logic [W:0]   add_b;
	logic         add_sub;
	logic [W+1:0] sum;
	logic         carry;
	logic         last;

	// operand select of the shared adder
	always_comb begin
		add_a   = {1'b0, a_q};
		add_b   = {1'b0, b_q};
		add_sub = 1'b0;
		case (state_q)
			A_ADDSUB: begin
				add_sub = (op_q == rse_pkg::REQ_SUB);
			end
			A_MUL: begin
				add_a = {1'b0, acc_q};
				add_b = {1'b0, a_q};
			end
			A_NEGA, A_NEGQ: begin
				add_a   = '0;
				add_b   = {1'b0, a_q};
				add_sub = 1'b1;
			end
			A_NEGB: begin
				add_a   = '0;
				add_b   = {1'b0, b_q};
				add_sub = 1'b1;
			end
			A_DIV: begin
				add_a   = {acc_q, a_q[W-1]};
				add_b   = {1'b0, b_q};
				add_sub = 1'b1;
			end
			default: begin
				add_sub = 1'b0;
			end
		endcase
	end

	// the one adder; carry out set means no borrow on subtract
	assign sum   = {1'b0, add_a} + {1'b0, add_b ^ {(W+1){add_sub}}} + (W+2)'(add_sub);
	assign carry = sum[W+1];
	assign last  = (cnt_q == CW'(W - 1));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= A_IDLE;
			op_q     <= rse_pkg::REQ_ADD;
			a_q      <= '0;
			b_q      <= '0;
			acc_q    <= '0;
			cnt_q    <= '0;
			sign_q   <= 1'b0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			case (state_q)
				A_IDLE: begin
					done_q <= 1'b0;
					if (req.start) begin
						op_q   <= req.op;
						a_q    <= a;
						b_q    <= b;
						acc_q  <= '0;
						cnt_q  <= '0;
						sign_q <= a[W-1] ^ b[W-1];
						case (req.op)
							rse_pkg::REQ_ADD, rse_pkg::REQ_SUB: state_q <= A_ADDSUB;
							rse_pkg::REQ_MUL:                   state_q <= A_MUL;
							rse_pkg::REQ_DIV:                   state_q <= A_NEGA;
							default:                            state_q <= A_IDLE;
						endcase
					end
				end
				A_ADDSUB: begin
					result_q <= sum[W-1:0];
					done_q   <= 1'b1;
					state_q  <= A_IDLE;
				end
				// shift-add, low half of the product only
				A_MUL: begin
					if (b_q[0]) begin
						acc_q <= sum[W-1:0];
					end
					a_q    <= {a_q[W-2:0], 1'b0};
					b_q    <= {1'b0, b_q[W-1:1]};
					cnt_q  <= cnt_q + CW'(1);
					done_q <= last;
					if (last) begin
						result_q <= b_q[0] ? sum[W-1:0] : acc_q;
						state_q  <= A_IDLE;
					end
				end
				// magnitudes of dividend and divisor
				A_NEGA: begin
					done_q <= 1'b0;
					if (a_q[W-1]) begin
						a_q <= sum[W-1:0];
					end
					state_q <= A_NEGB;
				end
				A_NEGB: begin
					done_q <= 1'b0;
					if (b_q[W-1]) begin
						b_q <= sum[W-1:0];
					end
					state_q <= A_DIV;
				end
				// restoring divide, one quotient bit per cycle
				A_DIV: begin
					done_q <= 1'b0;
					acc_q  <= carry ? sum[W-1:0] : add_a[W-1:0];
					a_q    <= {a_q[W-2:0], carry};
					cnt_q  <= cnt_q + CW'(1);
					if (last) begin
						state_q <= A_NEGQ;
					end
				end
				// quotient sign, truncation toward zero
				A_NEGQ: begin
					result_q <= sign_q ? sum[W-1:0] : a_q;
					done_q   <= 1'b1;
					state_q  <= A_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> design/rpn_stack_evaluator_core.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_core: reverse polish evaluator on a bounded stack
// tokens push, combine, store, recall and finish; one result beat per token
//
// channel  dir  signals                      beat contents (lowest bit up)
// s_*      in   s_tvalid s_tready s_tdata    operand_value[31:0]
//                s_tuser                     req_type[2:0]
// m_*      out  m_tvalid m_tready m_tdata    top_value[31:0] stack_count[4:0]
//                                            status[2:0]
//                m_tlast                     finished
//
// push, store, recall, finish and error cases go from the execute state straight to
// the response state; add, subtract, multiply and divide wait in the alu state,
// where the one shared adder of the alu steps multiply and divide a bit a cycle
// one token is in work at a time; s_tready is high only while idle, so the
// next token is taken at the earliest in the cycle after the result is registered
// a finished result waits in the output register while the next token is taken
// reset clears the stack pointer and the saved register; stack words are
// undefined until pushed
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_core #(
	parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF,
	parameter int DATA_WIDTH  = rse_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // operand_value[31:0]
	input  logic [2:0]  s_tuser,   // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // top_value[31:0] stack_count[36:32] status[39:37]
	output logic        m_tlast    // finished
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int PW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_ALU,
		S_RESP
	} seq_state_t;

	seq_state_t                   state_q;
	rse_pkg::req_type_t           op_q;
	logic [DATA_WIDTH-1:0]        arg_q;
	logic [PW-1:0]                sp_q;
	logic [DATA_WIDTH-1:0]        saved_q;
	logic [DATA_WIDTH-1:0]        res_top_q;
	rse_pkg::status_t             res_status_q;
	logic                         res_fin_q;
	rse_pkg::alu_req_t            alu_req_q;
	logic                         m_tvalid_q;
	logic [rse_pkg::TOP_W-1:0]    out_top_q;
	logic [rse_pkg::CNT_W-1:0]    out_cnt_q;
	logic [rse_pkg::STAT_W-1:0]   out_status_q;
	logic                         out_fin_q;

	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic [DATA_WIDTH-1:0] rd_x;
	logic [DATA_WIDTH-1:0] rd_y;
	logic                  alu_done;
	logic [DATA_WIDTH-1:0] alu_result;

	logic                  sp_empty;
	logic                  sp_full;
	logic                  sp_two;
	logic [DATA_WIDTH-1:0] top_cur;

	// stack status
	assign sp_empty = (sp_q == '0);
	assign sp_full  = (sp_q == PW'(STACK_DEPTH));
	assign sp_two   = (sp_q >= PW'(2));
	assign top_cur  = sp_empty ? '0 : rd_x;

	// stack write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = AW'(sp_q);
		wr_data = arg_q;
		case (state_q)
			S_EXEC: begin
				if (op_q == rse_pkg::REQ_PUSH && !sp_full) begin
					wr_en = 1'b1;
				end
				if (op_q == rse_pkg::REQ_RECALL && !sp_full) begin
					wr_en   = 1'b1;
					wr_data = saved_q;
				end
			end
			S_ALU: begin
				wr_en   = alu_done;
				wr_addr = AW'(sp_q - PW'(2));
				wr_data = alu_result;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// top two entries, read continuously from the current pointer
	rse_stack_ram #(
		.DEPTH (STACK_DEPTH),
		.W     (DATA_WIDTH),
		.AW    (AW)
	) u_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (AW'(sp_q - PW'(1))),
		.rd_addr_b (AW'(sp_q - PW'(2))),
		.rd_data_a (rd_x),
		.rd_data_b (rd_y)
	);

	// shared arithmetic unit; top of stack is the right operand
	rse_alu #(
		.W (DATA_WIDTH)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req_q),
		.a      (rd_y),
		.b      (rd_x),
		.done   (alu_done),
		.result (alu_result)
	);

	// token sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= rse_pkg::REQ_PUSH;
			arg_q        <= '0;
			sp_q         <= '0;
			saved_q      <= '0;
			res_top_q    <= '0;
			res_status_q <= rse_pkg::ST_OK;
			res_fin_q    <= 1'b0;
			alu_req_q    <= '0;
			m_tvalid_q   <= 1'b0;
			out_top_q    <= '0;
			out_cnt_q    <= '0;
			out_status_q <= '0;
			out_fin_q    <= 1'b0;
		end else begin
			// output beat taken; the response state loads it itself
			if (m_tready && state_q != S_RESP) begin
				m_tvalid_q <= 1'b0;
			end
			// alu start is a single-cycle pulse out of the execute state
			if (state_q != S_EXEC) begin
				alu_req_q.start <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= rse_pkg::req_type_t'(s_tuser);
						arg_q   <= DATA_WIDTH'($signed(s_tdata));
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_fin_q <= (op_q == rse_pkg::REQ_FINISH);
					case (op_q)
						rse_pkg::REQ_PUSH: begin
							state_q <= S_RESP;
							if (sp_full) begin
								res_status_q <= rse_pkg::ST_OVER;
								res_top_q    <= top_cur;
							end else begin
								sp_q         <= sp_q + PW'(1);
								res_status_q <= rse_pkg::ST_OK;
								res_top_q    <= arg_q;
							end
						end
						rse_pkg::REQ_ADD, rse_pkg::REQ_SUB,
						rse_pkg::REQ_MUL, rse_pkg::REQ_DIV: begin
							if (!sp_two) begin
								res_status_q <= rse_pkg::ST_UNDER;
								res_top_q    <= top_cur;
								state_q      <= S_RESP;
							end else if (op_q == rse_pkg::REQ_DIV && rd_x == '0) begin
								res_status_q <= rse_pkg::ST_DIVZ;
								res_top_q    <= rd_x;
								state_q      <= S_RESP;
							end else begin
								res_status_q    <= rse_pkg::ST_OK;
								alu_req_q.start <= 1'b1;
								alu_req_q.op    <= op_q;
								state_q         <= S_ALU;
							end
						end
						rse_pkg::REQ_STORE: begin
							state_q <= S_RESP;
							if (sp_empty) begin
								res_status_q <= rse_pkg::ST_UNDER;
								res_top_q    <= '0;
							end else begin
								saved_q      <= rd_x;
								res_status_q <= rse_pkg::ST_OK;
								res_top_q    <= rd_x;
							end
						end
						rse_pkg::REQ_RECALL: begin
							state_q <= S_RESP;
							if (sp_full) begin
								res_status_q <= rse_pkg::ST_OVER;
								res_top_q    <= top_cur;
							end else begin
								sp_q         <= sp_q + PW'(1);
								res_status_q <= rse_pkg::ST_OK;
								res_top_q    <= saved_q;
							end
						end
						rse_pkg::REQ_FINISH: begin
							state_q <= S_RESP;
							if (sp_empty) begin
								res_status_q <= rse_pkg::ST_UNDER;
								res_top_q    <= '0;
							end else begin
								res_top_q    <= rd_x;
								res_status_q <= sp_two ? rse_pkg::ST_INVALID : rse_pkg::ST_OK;
								sp_q         <= '0;
							end
						end
						default: begin
							state_q      <= S_RESP;
							res_status_q <= rse_pkg::ST_OK;
							res_top_q    <= top_cur;
						end
					endcase
				end
				// pop two, push the alu result
				S_ALU: begin
					if (alu_done) begin
						sp_q      <= sp_q - PW'(1);
						res_top_q <= alu_result;
						state_q   <= S_RESP;
					end
				end
				// hand the result to the output register once it is free
				S_RESP: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q   <= 1'b1;
						out_top_q    <= rse_pkg::TOP_W'(res_top_q);
						out_cnt_q    <= rse_pkg::CNT_W'(sp_q);
						out_status_q <= res_status_q;
						out_fin_q    <= res_fin_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_status_q, out_cnt_q, out_top_q};
	assign m_tlast  = out_fin_q;

	// stack pointer stays within the stack
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= PW'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	// alu answers only while the sequencer waits for it
	a_alu_done: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> state_q == S_ALU)
		else $error("alu done outside alu wait");

	// a finish result always leaves an empty stack
	a_fin_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_fin_q) |-> out_cnt_q == '0)
		else $error("finish result with entries left");

	// an output beat held under stall is not overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |=> $stable(out_top_q) && $stable(out_status_q))
		else $error("stalled result changed");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rpn_stack_evaluator_core
// drives token beats with random gaps, predicts every result beat from a
// behavioral stack calculator and compares it with the m_* beats, which are
// taken with random stalls; directed corner tokens first, then random
// expressions, full-stack runs and stray tokens
// ----------------------------------------------------------------------------
module testbench;

	localparam int DEPTH      = rse_pkg::STACK_DEPTH_DEF;
	localparam int N_TOKENS   = 1050;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYC   = 80;
	localparam int MAX_PRINTS = 100;

	typedef struct {
		rse_pkg::req_type_t op;
		logic [31:0]        value;
		bit                 drain;
	} rpn_token_t;

	typedef struct {
		logic [31:0]      top;
		logic [4:0]       depth;
		rse_pkg::status_t status;
		logic             done;
	} calc_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b1;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic [2:0]  s_tuser  = rse_pkg::REQ_PUSH;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	rpn_token_t   token_q[$];
	calc_result_t calc_results_due[$];
	rpn_token_t   live_tok;
	int           total_tokens;
	int           tokens_taken;
	int           err_cnt;
	int           gap_left;
	int           stall_left;
	int           idle_cycles;
	bit           src_calm;
	bit           snk_calm;

	// behavioral calculator state
	logic [31:0] calc_stack [DEPTH];
	int          calc_depth;
	logic [31:0] calc_saved;

	rse_pkg::req_type_t arith_ops [4] = '{rse_pkg::REQ_ADD, rse_pkg::REQ_SUB,
		rse_pkg::REQ_MUL, rse_pkg::REQ_DIV};

	rpn_stack_evaluator_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	// one token through the calculator, returns the result it causes
	function automatic calc_result_t rpn_eval_token(rse_pkg::req_type_t op, logic [31:0] val);
		calc_result_t res;
		logic [31:0]  lhs;
		logic [31:0]  rhs;
		logic [31:0]  r;
		longint       quo;
		res.status = rse_pkg::ST_OK;
		res.done   = 1'b0;
		r          = '0;
		case (op)
			rse_pkg::REQ_PUSH: begin
				if (calc_depth == DEPTH) res.status = rse_pkg::ST_OVER;
				else begin
					calc_stack[calc_depth] = val;
					calc_depth++;
				end
			end
			rse_pkg::REQ_ADD, rse_pkg::REQ_SUB, rse_pkg::REQ_MUL, rse_pkg::REQ_DIV: begin
				if (calc_depth < 2) res.status = rse_pkg::ST_UNDER;
				else begin
					rhs = calc_stack[calc_depth-1];
					lhs = calc_stack[calc_depth-2];
					case (op)
						rse_pkg::REQ_ADD: r = lhs + rhs;
						rse_pkg::REQ_SUB: r = lhs - rhs;
						rse_pkg::REQ_MUL: r = lhs * rhs;
						default: begin
							// truncating divide, wide enough that min / -1 wraps
							if (rhs == '0) res.status = rse_pkg::ST_DIVZ;
							else begin
								quo = longint'($signed(lhs)) / longint'($signed(rhs));
								r   = quo[31:0];
							end
						end
					endcase
					if (res.status == rse_pkg::ST_OK) begin
						calc_depth--;
						calc_stack[calc_depth-1] = r;
					end
				end
			end
			rse_pkg::REQ_STORE: begin
				if (calc_depth == 0) res.status = rse_pkg::ST_UNDER;
				else calc_saved = calc_stack[calc_depth-1];
			end
			rse_pkg::REQ_RECALL: begin
				if (calc_depth == DEPTH) res.status = rse_pkg::ST_OVER;
				else begin
					calc_stack[calc_depth] = calc_saved;
					calc_depth++;
				end
			end
			default: begin
				res.done = 1'b1;
			end
		endcase
		res.top = (calc_depth == 0) ? '0 : calc_stack[calc_depth-1];
		// finish pops the result and empties the stack
		if (res.done) begin
			if (calc_depth == 0) res.status = rse_pkg::ST_UNDER;
			else if (calc_depth > 1) res.status = rse_pkg::ST_INVALID;
			calc_depth = 0;
		end
		res.depth = 5'(calc_depth);
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (err_cnt < MAX_PRINTS)
			$display("mismatch %0s: got %h want %h at %0t", what, got, want, $realtime);
		err_cnt++;
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return '0;
			3:       return '1;
			4, 5, 6: return 32'(int'($urandom_range(0, 16)) - 8);
			default: return $urandom();
		endcase
	endfunction

	// non-push tokens carry a random, ignored operand
	task automatic queue_token(rse_pkg::req_type_t op, logic [31:0] val = '0,
		bit drain = 1'b0);
		rpn_token_t tok;
		tok.op    = op;
		tok.value = (op == rse_pkg::REQ_PUSH) ? val : $urandom();
		tok.drain = drain;
		token_q.insert(token_q.size(), tok);
	endtask

	// well-formed expression ending in finish
	task automatic gen_expression();
		int depth;
		int len;
		int k;
		depth = 0;
		len   = $urandom_range(2, 14);
		for (int i = 0; i < len; i++) begin
			if (depth < 2 || (depth < DEPTH - 1 && $urandom_range(0, 2) == 0)) begin
				if (depth > 0 && $urandom_range(0, 7) == 0) queue_token(rse_pkg::REQ_RECALL);
				else queue_token(rse_pkg::REQ_PUSH, pick_operand());
				depth++;
			end else begin
				k = $urandom_range(0, 9);
				if (k == 9) queue_token(rse_pkg::REQ_STORE);
				else begin
					queue_token(arith_ops[k % 4]);
					depth--;
				end
			end
		end
		while (depth > 1) begin
			queue_token(arith_ops[$urandom_range(0, 3)]);
			depth--;
		end
		queue_token(rse_pkg::REQ_FINISH);
	endtask

	// fill the stack to the top, hit overflow on push and recall, then unwind
	task automatic gen_fill();
		queue_token(rse_pkg::REQ_PUSH, pick_operand());
		queue_token(rse_pkg::REQ_STORE);
		repeat (DEPTH - 1) begin
			if ($urandom_range(0, 3) == 0) queue_token(rse_pkg::REQ_RECALL);
			else queue_token(rse_pkg::REQ_PUSH, pick_operand());
		end
		queue_token(rse_pkg::REQ_PUSH, pick_operand());
		queue_token(rse_pkg::REQ_RECALL);
		repeat ($urandom_range(0, DEPTH - 1)) queue_token(arith_ops[$urandom_range(0, 3)]);
		queue_token(rse_pkg::REQ_FINISH);
	endtask

	// token driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= rse_pkg::REQ_PUSH;
			gap_left = $urandom_range(0, 7);
		end else begin
			if (s_tvalid && s_tready) begin
				calc_results_due.insert(calc_results_due.size(),
					rpn_eval_token(live_tok.op, live_tok.value));
				tokens_taken++;
				if ($urandom_range(0, 31) == 0) src_calm = !src_calm;
				gap_left = src_calm ? 0 : $urandom_range(0, 7);
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (token_q.size() != 0 &&
				             !(token_q[0].drain && calc_results_due.size() != 0)) begin
					live_tok = token_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= live_tok.value;
					s_tuser  <= live_tok.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and checker
	always @(posedge clk or negedge arst_n) begin
		calc_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 7);
		end else begin
			if (m_tvalid && m_tready) begin
				if (calc_results_due.size() == 0) begin
					report_mismatch("unexpected beat", m_tdata[31:0], '0);
				end else begin
					want = calc_results_due.pop_front();
					if (m_tdata[31:0] !== want.top)
						report_mismatch("top_value", m_tdata[31:0], want.top);
					if (m_tdata[36:32] !== want.depth)
						report_mismatch("stack_count", 32'(m_tdata[36:32]), 32'(want.depth));
					if (m_tdata[39:37] !== want.status)
						report_mismatch("status", 32'(m_tdata[39:37]), 32'(want.status));
					if (m_tlast !== want.done)
						report_mismatch("finished", 32'(m_tlast), 32'(want.done));
				end
				if ($urandom_range(0, 31) == 0) snk_calm = !snk_calm;
				stall_left = snk_calm ? 0 : $urandom_range(0, 7);
			end
			if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	initial begin
		int first;
		int pick;
		arst_n       = 1'b0;
		err_cnt      = 0;
		tokens_taken = 0;
		idle_cycles  = 0;
		src_calm     = 1'b0;
		snk_calm     = 1'b0;
		calc_depth   = 0;
		calc_saved   = '0;

		// directed: empty-stack errors and the recall of a cleared register
		queue_token(rse_pkg::REQ_FINISH);
		queue_token(rse_pkg::REQ_ADD);
		queue_token(rse_pkg::REQ_STORE);
		queue_token(rse_pkg::REQ_RECALL);
		queue_token(rse_pkg::REQ_SUB);
		queue_token(rse_pkg::REQ_FINISH);
		// add wraps, most negative over -1 wraps, zero divisor
		queue_token(rse_pkg::REQ_PUSH, 32'h7fff_ffff);
		queue_token(rse_pkg::REQ_PUSH, 32'h0000_0001);
		queue_token(rse_pkg::REQ_ADD);
		queue_token(rse_pkg::REQ_PUSH, 32'hffff_ffff);
		queue_token(rse_pkg::REQ_DIV);
		queue_token(rse_pkg::REQ_STORE);
		queue_token(rse_pkg::REQ_PUSH, 32'h0000_0000);
		queue_token(rse_pkg::REQ_DIV);
		queue_token(rse_pkg::REQ_SUB);
		queue_token(rse_pkg::REQ_RECALL);
		queue_token(rse_pkg::REQ_MUL);
		// truncation toward zero and finish with entries left
		queue_token(rse_pkg::REQ_PUSH, 32'd7);
		queue_token(rse_pkg::REQ_PUSH, -32'sd2);
		queue_token(rse_pkg::REQ_DIV);
		queue_token(rse_pkg::REQ_FINISH);
		// sender holds off here until all results are back
		queue_token(rse_pkg::REQ_PUSH, -32'sd7, 1'b1);
		queue_token(rse_pkg::REQ_PUSH, 32'd2);
		queue_token(rse_pkg::REQ_DIV);
		queue_token(rse_pkg::REQ_FINISH);

		// random part, opening with a full-stack run
		gen_fill();
		while (token_q.size() < N_TOKENS) begin
			first = token_q.size();
			pick  = $urandom_range(0, 19);
			if (pick < 14) gen_expression();
			else if (pick < 15) gen_fill();
			else repeat ($urandom_range(1, 5))
				queue_token(rse_pkg::req_type_t'($urandom_range(0, 7)), $urandom());
			if ($urandom_range(0, 24) == 0) token_q[first].drain = 1'b1;
		end
		total_tokens = token_q.size();

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (tokens_taken != total_tokens || calc_results_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYC) @(negedge clk);

		if (err_cnt == 0 && calc_results_due.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

>>> rpn_stack_evaluator_core.f
design/rse_pkg.sv
design/rse_stack_ram.sv
design/rse_alu.sv
design/rpn_stack_evaluator_core.sv
tb/testbench.sv
